@@ hdl/hq_pkg.sv @@
`default_nettype none
package hq_pkg;

  // Queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key;
  } hq_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } hq_out_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } hq_cmd_t;

endpackage
`default_nettype wire

@@ hdl/binary_max_heap_queue.sv @@
`default_nettype none
// Bounded max-priority queue of signed 32-bit keys.
// Input: pulse start with in_item (operation, key) while busy is low; the
// command is taken at that clock edge. busy never rises, so a command may
// be issued every cycle.
// Result: in the cycle after each command, out_valid is high for exactly one
// cycle with out_item (removed_value, status, occupancy). Throughput is one
// command per cycle.
// Insert places the key into a chain of CAPACITY cells kept sorted in
// descending order; every cell compares against the new key in parallel
// and hands its key to its right neighbor when it must make room. Remove
// returns the head cell and every cell takes its right neighbor's key.
// An insert into a full queue is dropped (status full); a remove from an
// empty queue answers empty with value 0.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid;
// cell contents are not cleared, slots past the count are never read.
// The receiver cannot stall: each result is shown for one cycle only.
module binary_max_heap_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire hq_pkg::hq_in_t   in_item,
  output logic                  out_valid,
  output hq_pkg::hq_out_t       out_item
);

  localparam int N = hq_pkg::CAPACITY;

  logic [hq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                     out_valid_r;
  hq_pkg::hq_out_t          out_r, out_nxt;
  hq_pkg::hq_cmd_t          cmd;
  logic                     accept;
  logic                     is_full, is_empty;

  logic signed [hq_pkg::KEY_W-1:0] cell_key [N];
  logic                            cell_gt  [N];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_full   = (count_r == hq_pkg::CNT_W'(N));
  assign is_empty  = (count_r == '0);

  // Decode the command and build the result
  always_comb begin
    cmd           = '0;
    count_nxt     = count_r;
    out_nxt       = '0;
    if (in_item.operation == hq_pkg::OP_INSERT) begin
      if (is_full) begin
        out_nxt.status = hq_pkg::ST_FULL;
      end else begin
        cmd.insert     = accept;
        count_nxt      = count_r + 1'b1;
        out_nxt.status = hq_pkg::ST_INSERTED;
      end
    end else begin
      if (is_empty) begin
        out_nxt.status = hq_pkg::ST_EMPTY;
      end else begin
        cmd.remove            = accept;
        count_nxt             = count_r - 1'b1;
        out_nxt.status        = hq_pkg::ST_REMOVED;
        out_nxt.removed_value = cell_key[0];
      end
    end
    out_nxt.occupancy = hq_pkg::OCC_W'(count_nxt);
  end

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [hq_pkg::KEY_W-1:0] left_key, right_key;
    logic                            left_gt;
    if (i == 0) begin : g_head
      assign left_key = cell_key[0];
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    hq_cell u_cell (
      .clk         (clk),
      .cmd_i       (cmd),
      .new_key_i   (in_item.key),
      .valid_i     (hq_pkg::CNT_W'(i) < count_r),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ hdl/hq_cell.sv @@
`default_nettype none
// One slot of the sorted chain. Keys stay in descending order from cell 0.
module hq_cell (
  input  wire                                    clk,
  input  wire hq_pkg::hq_cmd_t                   cmd_i,
  input  wire logic signed [hq_pkg::KEY_W-1:0]   new_key_i,
  input  wire logic                              valid_i,
  input  wire logic signed [hq_pkg::KEY_W-1:0]   left_key_i,
  input  wire logic                              left_gt_i,
  input  wire logic signed [hq_pkg::KEY_W-1:0]   right_key_i,
  output logic signed [hq_pkg::KEY_W-1:0]        key_o,
  output logic                                   gt_o
);

  logic signed [hq_pkg::KEY_W-1:0] key_r;
  logic signed [hq_pkg::KEY_W-1:0] key_nxt;

  // New key belongs at or ahead of this slot
  assign gt_o  = !valid_i || (new_key_i > key_r);
  assign key_o = key_r;

  // Insert: take the left neighbor if it also moves, else the new key.
  // Remove: everything moves one slot toward the head.
  always_comb begin
    key_nxt = key_r;
    if (cmd_i.insert && gt_o) begin
      key_nxt = left_gt_i ? left_key_i : new_key_i;
    end else if (cmd_i.remove) begin
      key_nxt = right_key_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire
